@@ hdl/touch_gesture_classifier_assert.svh @@
// Assertion macros used by the classifier RTL.
`ifndef TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH
`define TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TGC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tgc assertion failed");

// Next-cycle implication.
`define TGC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tgc assertion failed");

`else

`define TGC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TGC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/tgc_pkg.sv @@
package tgc_pkg;

   // Event kinds.
   localparam logic [2:0] KIND_BEGIN  = 3'd0;
   localparam logic [2:0] KIND_END    = 3'd1;
   localparam logic [2:0] KIND_PAN    = 3'd2;
   localparam logic [2:0] KIND_TAP    = 3'd3;
   localparam logic [2:0] KIND_ZOOM   = 3'd4;
   localparam logic [2:0] KIND_SCROLL = 3'd5;

   // Event flag values and bits.
   localparam logic [2:0] FLAGS_BEGIN = 3'd1;
   localparam logic [2:0] FLAGS_END   = 3'd4;
   localparam int unsigned FLAG_BEGIN_BIT = 0;

   // Action codes.
   localparam logic [3:0] ACTION_IDLE        = 4'd0;
   localparam logic [3:0] ACTION_JBACK_SHORT = 4'd0;
   localparam logic [3:0] ACTION_JBACK_MED   = 4'd1;
   localparam logic [3:0] ACTION_JFWD_SHORT  = 4'd2;
   localparam logic [3:0] ACTION_JFWD_MED    = 4'd3;
   localparam logic [3:0] ACTION_VOL_UP      = 4'd4;
   localparam logic [3:0] ACTION_VOL_DOWN    = 4'd5;
   localparam logic [3:0] ACTION_PLAY_PAUSE  = 4'd6;
   localparam logic [3:0] ACTION_TOGGLE_FULL = 4'd7;
   localparam logic [3:0] ACTION_LEAVE_FULL  = 4'd8;
   localparam logic [3:0] ACTION_FOV_IN      = 4'd9;
   localparam logic [3:0] ACTION_FOV_OUT     = 4'd10;

   // Pan classes.
   localparam logic [1:0] CLASS_NONE   = 2'd0;
   localparam logic [1:0] CLASS_VOLUME = 2'd1;
   localparam logic [1:0] CLASS_JUMP   = 2'd2;
   localparam logic [1:0] CLASS_BRIGHT = 2'd3;

   // Register indexes and reset values.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROJECTED = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOL_STEP  = 2'd2;
   localparam logic [9:0] THRESHOLD_RESET = 10'd50;
   localparam logic [9:0] VOL_STEP_RESET  = 10'd100;

   // Zoom ratio limits as integer percentages.
   localparam logic [6:0] ZOOM_PCT_BASE = 7'd100;
   localparam logic [6:0] ZOOM_PCT_IN   = 7'd101;
   localparam logic [6:0] ZOOM_PCT_OUT  = 7'd99;

   typedef struct packed {
      logic       projected_mode;
      logic [9:0] travel_threshold;
      logic [9:0] volume_step;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         event_kind;
      logic [2:0]         event_flags;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [31:0]        argument;
   } event_type;

   typedef struct packed {
      logic               gesture_seen;
      logic [1:0]         pan_class;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic signed [15:0] last_y;
      logic               two_fingers;
      logic [31:0]        zoom_base;
      logic [31:0]        zoom_last;
   } state_type;

   typedef struct packed {
      logic       handled;
      logic       action_valid;
      logic [3:0] action_code;
      logic       bad_flags;
   } result_type;

endpackage

@@ hdl/tgc_req_if.sv @@
interface tgc_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         event_kind;
   logic [2:0]         event_flags;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [31:0]        argument;

   modport source (output valid, event_kind, event_flags, pos_x, pos_y, argument,
                   input ready);
   modport sink (input valid, event_kind, event_flags, pos_x, pos_y, argument,
                 output ready);
endinterface

@@ hdl/tgc_rsp_if.sv @@
interface tgc_rsp_if;
   logic       valid;
   logic       ready;
   logic       handled;
   logic       action_valid;
   logic [3:0] action_code;
   logic       bad_flags;

   modport source (output valid, handled, action_valid, action_code, bad_flags,
                   input ready);
   modport sink (input valid, handled, action_valid, action_code, bad_flags,
                 output ready);
endinterface

@@ hdl/tgc_step.sv @@
module tgc_step (
   input  tgc_pkg::cfg_type    cfg,
   input  tgc_pkg::event_type  evt,
   input  tgc_pkg::state_type  state_cur,
   output tgc_pkg::state_type  state_next,
   output tgc_pkg::result_type result
);
   import tgc_pkg::*;

   // Pan geometry.
   logic signed [15:0] pan_sx;
   logic signed [15:0] pan_sy;
   logic               pan_two;
   logic signed [16:0] diff_x;
   logic signed [16:0] diff_y;
   logic [16:0]        dist_x;
   logic [16:0]        dist_y;
   logic [17:0]        travel;
   logic [1:0]         pan_class_new;
   logic signed [16:0] vol_off;
   logic signed [16:0] vol_lim;
   logic               jump_back;

   // Zoom cross products.
   logic [38:0] zoom_lhs;
   logic [38:0] zoom_in_rhs;
   logic [38:0] zoom_out_rhs;

   // Start point after an optional begin flag, and two-finger flag after this beat.
   assign pan_sx  = evt.event_flags[FLAG_BEGIN_BIT] ? evt.pos_x : state_cur.start_x;
   assign pan_sy  = evt.event_flags[FLAG_BEGIN_BIT] ? evt.pos_y : state_cur.start_y;
   assign pan_two = state_cur.two_fingers | (evt.argument != 32'd0);

   assign diff_x = {pan_sx[15], pan_sx} - {evt.pos_x[15], evt.pos_x};
   assign diff_y = {pan_sy[15], pan_sy} - {evt.pos_y[15], evt.pos_y};
   assign dist_x = diff_x[16] ? 17'(-diff_x) : 17'(diff_x);
   assign dist_y = diff_y[16] ? 17'(-diff_y) : 17'(diff_y);
   assign travel = {1'b0, dist_x} + {1'b0, dist_y};

   // Classify the pan once travel passes the threshold.
   always_comb begin
      pan_class_new = state_cur.pan_class;
      if (state_cur.pan_class == CLASS_NONE && (!cfg.projected_mode || pan_two) &&
          travel > {8'd0, cfg.travel_threshold}) begin
         if (dist_x > dist_y) begin
            pan_class_new = CLASS_JUMP;
         end else if (!cfg.projected_mode && pan_two) begin
            pan_class_new = CLASS_BRIGHT;
         end else begin
            pan_class_new = CLASS_VOLUME;
         end
      end
   end

   assign vol_off   = {state_cur.last_y[15], state_cur.last_y} - {evt.pos_y[15], evt.pos_y};
   assign vol_lim   = $signed({7'd0, cfg.volume_step});
   assign jump_back = state_cur.start_x > evt.pos_x;

   assign zoom_lhs     = 39'(evt.argument) * 39'(ZOOM_PCT_BASE);
   assign zoom_in_rhs  = 39'(state_cur.zoom_last) * 39'(ZOOM_PCT_IN);
   assign zoom_out_rhs = 39'(state_cur.zoom_last) * 39'(ZOOM_PCT_OUT);

   // Next state and result for one event.
   always_comb begin
      state_next          = state_cur;
      result.handled      = 1'b0;
      result.action_valid = 1'b0;
      result.action_code  = ACTION_IDLE;
      result.bad_flags    = 1'b0;
      unique case (evt.event_kind)
         KIND_BEGIN: begin
            state_next.start_x     = evt.pos_x;
            state_next.start_y     = evt.pos_y;
            state_next.last_y      = evt.pos_y;
            state_next.two_fingers = 1'b0;
         end
         KIND_END: begin
            if (state_cur.gesture_seen && state_cur.pan_class == CLASS_JUMP) begin
               if (cfg.projected_mode) begin
                  if (state_cur.two_fingers) begin
                     result.action_valid = 1'b1;
                     result.action_code  = jump_back ? ACTION_JBACK_SHORT : ACTION_JFWD_SHORT;
                  end
               end else begin
                  result.action_valid = 1'b1;
                  if (jump_back) begin
                     result.action_code = state_cur.two_fingers ? ACTION_JBACK_MED
                                                                : ACTION_JBACK_SHORT;
                  end else begin
                     result.action_code = state_cur.two_fingers ? ACTION_JFWD_MED
                                                                : ACTION_JFWD_SHORT;
                  end
               end
            end
            state_next.pan_class    = CLASS_NONE;
            state_next.gesture_seen = 1'b1;
            state_next.start_x      = '1;
            state_next.start_y      = '1;
            state_next.two_fingers  = 1'b0;
         end
         KIND_PAN: begin
            state_next.gesture_seen = 1'b1;
            state_next.start_x      = pan_sx;
            state_next.start_y      = pan_sy;
            state_next.two_fingers  = pan_two;
            state_next.pan_class    = pan_class_new;
            result.handled          = 1'b1;
            if (pan_class_new == CLASS_VOLUME) begin
               if (vol_off > vol_lim) begin
                  result.action_valid = 1'b1;
                  result.action_code  = ACTION_VOL_UP;
                  state_next.last_y   = evt.pos_y;
               end else if (vol_off < -vol_lim) begin
                  result.action_valid = 1'b1;
                  result.action_code  = ACTION_VOL_DOWN;
                  state_next.last_y   = evt.pos_y;
               end
            end
         end
         KIND_TAP: begin
            state_next.gesture_seen = 1'b1;
            result.handled          = 1'b1;
            result.action_valid     = 1'b1;
            result.action_code      = ACTION_PLAY_PAUSE;
         end
         KIND_ZOOM: begin
            state_next.gesture_seen = 1'b1;
            result.handled          = 1'b1;
            if (cfg.projected_mode) begin
               if (evt.event_flags == FLAGS_BEGIN) begin
                  state_next.zoom_base = evt.argument;
                  state_next.zoom_last = evt.argument;
               end else if (zoom_lhs > zoom_in_rhs) begin
                  result.action_valid  = 1'b1;
                  result.action_code   = ACTION_FOV_IN;
                  state_next.zoom_last = evt.argument;
               end else if (zoom_lhs < zoom_out_rhs) begin
                  result.action_valid  = 1'b1;
                  result.action_code   = ACTION_FOV_OUT;
                  state_next.zoom_last = evt.argument;
               end
            end else begin
               if (evt.event_flags == FLAGS_BEGIN) begin
                  state_next.zoom_base = evt.argument;
               end else if (evt.event_flags == FLAGS_END) begin
                  result.action_valid = 1'b1;
                  result.action_code  = (evt.argument > state_cur.zoom_base)
                                        ? ACTION_TOGGLE_FULL : ACTION_LEAVE_FULL;
               end else begin
                  result.bad_flags = 1'b1;
               end
            end
         end
         KIND_SCROLL: begin
            result.handled = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ hdl/touch_gesture_classifier.sv @@
// Touch gesture classifier: takes one gesture event per beat on the request
// channel and returns exactly one result beat per event, in the cycle after the
// event is accepted. All state tracking and classification is combinational
// between the accepted request and the result register, so a new event is
// accepted every cycle as long as the result side keeps up; request ready
// drops only while a finished result waits on a stalled response channel.
// Write the three control registers through the csr port only while no event
// is in flight (unchecked by the block); new rules apply from the next event.
`include "touch_gesture_classifier_assert.svh"

module touch_gesture_classifier (
   input  logic                                 clock,
   input  logic                                 reset,
   tgc_req_if.sink                              req_chan,
   tgc_rsp_if.source                            rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [tgc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tgc_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import tgc_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   state_type  state_ff;
   state_type  state_in;
   result_type rsp_ff;
   result_type result_calc;
   event_type  evt;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_accept;

   // Handshake: take a beat whenever the result register is empty or draining.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_valid_in   = req_accept || (rsp_valid_ff && !rsp_chan.ready);

   assign evt.event_kind  = req_chan.event_kind;
   assign evt.event_flags = req_chan.event_flags;
   assign evt.pos_x       = req_chan.pos_x;
   assign evt.pos_y       = req_chan.pos_y;
   assign evt.argument    = req_chan.argument;

   // Per-event state update and result.
   tgc_step u_step (
      .cfg        (cfg_ff),
      .evt        (evt),
      .state_cur  (state_ff),
      .state_next (state_in),
      .result     (result_calc)
   );

   // Control register writes; unused indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PROJECTED: cfg_in.projected_mode   = csr_write_data[0];
            CSR_THRESHOLD: cfg_in.travel_threshold = csr_write_data;
            CSR_VOL_STEP:  cfg_in.volume_step      = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.projected_mode   <= 1'b0;
         cfg_ff.travel_threshold <= THRESHOLD_RESET;
         cfg_ff.volume_step      <= VOL_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Gesture state advances on each accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.gesture_seen <= 1'b0;
         state_ff.pan_class    <= CLASS_NONE;
         state_ff.start_x      <= '1;
         state_ff.start_y      <= '1;
         state_ff.last_y       <= '1;
         state_ff.two_fingers  <= 1'b0;
         state_ff.zoom_base    <= '0;
         state_ff.zoom_last    <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= result_calc;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.handled      = rsp_ff.handled;
   assign rsp_chan.action_valid = rsp_ff.action_valid;
   assign rsp_chan.action_code  = rsp_ff.action_code;
   assign rsp_chan.bad_flags    = rsp_ff.bad_flags;

   // Checks on the result register and the gesture state.
   `TGC_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid_ff)
   `TGC_ASSERT_NEXT(a_beat_lands, clock, reset, req_accept, rsp_valid_ff)
   `TGC_ASSERT_IMPLY(a_idle_code, clock, reset,
                     rsp_valid_ff && !rsp_ff.action_valid,
                     rsp_ff.action_code == ACTION_IDLE)
   `TGC_ASSERT_IMPLY(a_bad_is_quiet, clock, reset,
                     rsp_valid_ff && rsp_ff.bad_flags,
                     rsp_ff.handled && !rsp_ff.action_valid)
   `TGC_ASSERT_NEXT(a_end_clears, clock, reset,
                    req_accept && req_chan.event_kind == KIND_END,
                    state_ff.pan_class == CLASS_NONE && !state_ff.two_fingers &&
                    state_ff.gesture_seen)

endmodule
